// ===== sv/cbs_pkg.sv =====
// cbs_pkg: shared types and command codes for the clip box set engine.
// No dependencies; used by cbs_cell, cbs_chain and clip_box_set_engine.
`default_nettype none

package cbs_pkg;

    // One stored box, signed fixed point, p1 = (x1, y1), p2 = (x2, y2)
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
    } box_t;

    // Cell commands, broadcast along the chain
    localparam logic [1:0] CELL_HOLD = 2'd0;  // keep contents
    localparam logic [1:0] CELL_ROT  = 2'd1;  // take the right neighbor
    localparam logic [1:0] CELL_SORT = 2'd2;  // odd-even swap of dead/live pairs
    localparam logic [1:0] CELL_LOAD = 2'd3;  // addressed cell takes the write box

    // Control seen by one cell
    typedef struct packed {
        logic [1:0] op;
        logic       pair_right;  // in this sort phase the partner is cell i+1
    } cell_ctl_t;

    // Control seen by the whole chain
    typedef struct packed {
        logic [1:0] op;
        logic       phase;       // sort phase parity
    } chain_ctl_t;

endpackage

`default_nettype wire

// ===== sv/cbs_cell.sv =====
// cbs_cell: one storage cell of the box chain, holds a box and a dead mark.
// Depends on cbs_pkg.
`default_nettype none

module cbs_cell (
    input  wire logic              aclk,
    input  wire cbs_pkg::cell_ctl_t ctl,
    input  wire logic              wr_en,
    input  wire cbs_pkg::box_t     wr_box,
    input  wire cbs_pkg::box_t     left_box,
    input  wire logic              left_dead,
    input  wire cbs_pkg::box_t     right_box,
    input  wire logic              right_dead,
    output cbs_pkg::box_t          box_out,
    output logic                   dead_out
);

    cbs_pkg::box_t box_reg, box_next;
    logic          dead_reg, dead_next;

    always_comb begin
        box_next  = box_reg;
        dead_next = dead_reg;
        unique case (ctl.op)
            cbs_pkg::CELL_HOLD: begin
            end
            cbs_pkg::CELL_ROT: begin
                box_next  = right_box;
                dead_next = right_dead;
            end
            cbs_pkg::CELL_SORT: begin
                // move live boxes down past dead ones, order of live kept
                if (ctl.pair_right) begin
                    if (dead_reg && !right_dead) begin
                        box_next  = right_box;
                        dead_next = right_dead;
                    end
                end else begin
                    if (left_dead && !dead_reg) begin
                        box_next  = left_box;
                        dead_next = left_dead;
                    end
                end
            end
            cbs_pkg::CELL_LOAD: begin
                if (wr_en) begin
                    box_next  = wr_box;
                    dead_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        box_reg  <= box_next;
        dead_reg <= dead_next;
    end

    assign box_out  = box_reg;
    assign dead_out = dead_reg;

endmodule

`default_nettype wire

// ===== sv/cbs_chain.sv =====
// cbs_chain: row of cbs_cell instances with neighbor wiring and write decode.
// Depends on cbs_pkg and cbs_cell.
`default_nettype none

module cbs_chain #(
    parameter int MAX_BOXES = 16,
    parameter int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
    input  wire logic                aclk,
    input  wire cbs_pkg::chain_ctl_t ctl,
    input  wire logic [IDX_W-1:0]    wr_idx,
    input  wire cbs_pkg::box_t       wr_box,
    input  wire cbs_pkg::box_t       tail_box,
    input  wire logic                tail_dead,
    output cbs_pkg::box_t            head_box,
    output logic                     head_dead
);

    cbs_pkg::box_t box_q  [MAX_BOXES];
    logic          dead_q [MAX_BOXES];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BOXES; gi++) begin : g_cell
            cbs_pkg::cell_ctl_t cctl;
            cbs_pkg::box_t      lbox, rbox;
            logic               ldead, rdead;

            assign cctl.op         = ctl.op;
            assign cctl.pair_right = (gi % 2 == 1) ? ctl.phase : !ctl.phase;

            if (gi == 0) begin : g_first
                assign lbox  = '0;
                assign ldead = 1'b0;
            end else begin : g_mid_l
                assign lbox  = box_q[gi-1];
                assign ldead = dead_q[gi-1];
            end

            if (gi == MAX_BOXES - 1) begin : g_last
                assign rbox  = tail_box;
                assign rdead = tail_dead;
            end else begin : g_mid_r
                assign rbox  = box_q[gi+1];
                assign rdead = dead_q[gi+1];
            end

            cbs_cell u_cell (
                .aclk       (aclk),
                .ctl        (cctl),
                .wr_en      (wr_idx == IDX_W'(gi)),
                .wr_box     (wr_box),
                .left_box   (lbox),
                .left_dead  (ldead),
                .right_box  (rbox),
                .right_dead (rdead),
                .box_out    (box_q[gi]),
                .dead_out   (dead_q[gi])
            );
        end
    endgenerate

    assign head_box  = box_q[0];
    assign head_dead = dead_q[0];

endmodule

`default_nettype wire

// ===== sv/clip_box_set_engine.sv =====
// clip_box_set_engine: top level, sequencer, extents and result register.
// Depends on cbs_pkg and cbs_chain (which uses cbs_cell).
//
//  channel | ports                        | handshake        | content
//  --------+------------------------------+------------------+-------------------------
//  input   | s_op, s_box_*                | s_valid/s_ready  | one operation + box
//  result  | m_contained ... m_overflow   | m_valid/m_ready  | state after the operation
//
// Sequence: clear, append and the short intersect cases go straight to the
// result. A contains within the extents with boxes held does one full rotation
// of the cell chain. A clamping intersect does a clamp rotation and an odd-even
// compaction, plus an extents rotation when the extents must be rebuilt.
// Reset (aresetn low, synchronous) empties the clip and drops any pending result.
// s_ready is high only while idle; a finished result waits in the output
// register and the engine may take the next transaction meanwhile, holding
// before its own result until m_ready frees the register.
`default_nettype none

module clip_box_set_engine #(
    parameter int MAX_BOXES = 16,
    parameter int FRAC_BITS = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_op,
    input  wire logic signed [31:0] s_box_left,
    input  wire logic signed [31:0] s_box_top,
    input  wire logic signed [31:0] s_box_right,
    input  wire logic signed [31:0] s_box_bottom,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_contained,
    output logic                    m_everything_clipped,
    output logic                    m_unclipped,
    output logic [4:0]              m_count_out,
    output logic signed [23:0]      m_extent_x,
    output logic signed [23:0]      m_extent_y,
    output logic [23:0]             m_extent_width,
    output logic [23:0]             m_extent_height,
    output logic                    m_overflow
);

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int EXT_W = 34;  // rounded coordinates incl. ceil carry

    localparam logic signed [EXT_W-1:0] ROUND_ADD =
        EXT_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [EXT_W-1:0] S24_MIN = -(EXT_W'(64'd8388608));
    localparam logic signed [EXT_W-1:0] S24_MAX = EXT_W'(64'd8388607);
    localparam logic signed [EXT_W:0]   U24_MAX = (EXT_W+1)'(64'd16777215);

    // operation codes
    localparam logic [1:0] OP_CLEAR     = 2'd0;
    localparam logic [1:0] OP_APPEND    = 2'd1;
    localparam logic [1:0] OP_INTERSECT = 2'd2;
    localparam logic [1:0] OP_CONTAINS  = 2'd3;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROT  = 2'd1;
    localparam logic [1:0] ST_SORT = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // what a rotation pass does at the chain head
    localparam logic [1:0] MODE_CLAMP = 2'd0;
    localparam logic [1:0] MODE_EXT   = 2'd1;
    localparam logic [1:0] MODE_HIT   = 2'd2;

    function automatic logic signed [EXT_W-1:0] rfloor(input logic signed [31:0] v);
        logic signed [EXT_W-1:0] w;
        w = {{(EXT_W-32){v[31]}}, v};
        return w >>> FRAC_BITS;
    endfunction

    function automatic logic signed [EXT_W-1:0] rceil(input logic signed [31:0] v);
        logic signed [EXT_W-1:0] w;
        w = {{(EXT_W-32){v[31]}}, v} + ROUND_ADD;
        return w >>> FRAC_BITS;
    endfunction

    function automatic logic [23:0] sat_s24(input logic signed [EXT_W-1:0] v);
        logic [23:0] r;
        if (v < S24_MIN)      r = 24'h800000;
        else if (v > S24_MAX) r = 24'h7FFFFF;
        else                  r = v[23:0];
        return r;
    endfunction

    function automatic logic [23:0] sat_u24(input logic signed [EXT_W-1:0] hi,
                                            input logic signed [EXT_W-1:0] lo);
        logic signed [EXT_W:0] d;
        logic [23:0]           r;
        d = {hi[EXT_W-1], hi} - {lo[EXT_W-1], lo};
        if (d < 0)            r = 24'd0;
        else if (d > U24_MAX) r = 24'hFFFFFF;
        else                  r = d[23:0];
        return r;
    endfunction

    function automatic logic holds(input cbs_pkg::box_t outer, input cbs_pkg::box_t inner);
        return inner.x1 >= outer.x1 && inner.y1 >= outer.y1 &&
               inner.x2 <= outer.x2 && inner.y2 <= outer.y2;
    endfunction

    // ---------------- state ----------------
    logic [1:0]              state_reg, state_next;
    logic [1:0]              mode_reg, mode_next;
    logic [IDX_W-1:0]        step_reg, step_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        keep_reg, keep_next;
    logic                    clip_reg, clip_next;
    logic                    allc_reg, allc_next;
    logic                    chg_reg, chg_next;
    logic                    hit_reg, hit_next;
    logic                    ovf_reg, ovf_next;
    logic signed [EXT_W-1:0] ex1_reg, ex1_next, ey1_reg, ey1_next;
    logic signed [EXT_W-1:0] ex2_reg, ex2_next, ey2_reg, ey2_next;
    cbs_pkg::box_t           q_reg, q_next;
    cbs_pkg::box_t           acc_reg, acc_next;

    logic                    mv_reg, mv_next;
    logic                    o_cont_reg, o_allc_reg, o_uncl_reg, o_ovf_reg;
    logic [4:0]              o_cnt_reg;
    logic [23:0]             o_x_reg, o_y_reg, o_w_reg, o_h_reg;

    // ---------------- chain ----------------
    cbs_pkg::chain_ctl_t     cctl;
    logic [IDX_W-1:0]        wr_idx;
    cbs_pkg::box_t           head_box, tail_box;
    logic                    head_dead, tail_dead;

    cbs_chain #(
        .MAX_BOXES (MAX_BOXES),
        .IDX_W     (IDX_W)
    ) u_chain (
        .aclk      (aclk),
        .ctl       (cctl),
        .wr_idx    (wr_idx),
        .wr_box    (q_next),
        .tail_box  (tail_box),
        .tail_dead (tail_dead),
        .head_box  (head_box),
        .head_dead (head_dead)
    );

    // incoming box and its rounded form
    cbs_pkg::box_t           in_box;
    logic signed [EXT_W-1:0] rx1, ry1, rx2, ry2;
    logic                    accept;

    assign in_box.x1 = s_box_left;
    assign in_box.y1 = s_box_top;
    assign in_box.x2 = s_box_right;
    assign in_box.y2 = s_box_bottom;
    assign rx1 = rfloor(s_box_left);
    assign ry1 = rfloor(s_box_top);
    assign rx2 = rceil(s_box_right);
    assign ry2 = rceil(s_box_bottom);

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // head processing during rotation
    cbs_pkg::box_t  clamped;
    logic           in_use, clamp_chg, clamp_live, last_step;

    assign in_use    = {{(CNT_W-IDX_W){1'b0}}, step_reg} < count_reg;
    assign last_step = (step_reg == IDX_W'(MAX_BOXES - 1));

    always_comb begin
        clamped   = head_box;
        clamp_chg = 1'b0;
        if (q_reg.x1 > head_box.x1) begin clamped.x1 = q_reg.x1; clamp_chg = 1'b1; end
        if (q_reg.x2 < head_box.x2) begin clamped.x2 = q_reg.x2; clamp_chg = 1'b1; end
        if (q_reg.y1 > head_box.y1) begin clamped.y1 = q_reg.y1; clamp_chg = 1'b1; end
        if (q_reg.y2 < head_box.y2) begin clamped.y2 = q_reg.y2; clamp_chg = 1'b1; end
        clamp_live = (clamped.x2 > clamped.x1) && (clamped.y2 > clamped.y1);
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        step_next  = step_reg;
        count_next = count_reg;
        keep_next  = keep_reg;
        clip_next  = clip_reg;
        allc_next  = allc_reg;
        chg_next   = chg_reg;
        hit_next   = hit_reg;
        ovf_next   = ovf_reg;
        ex1_next   = ex1_reg;
        ey1_next   = ey1_reg;
        ex2_next   = ex2_reg;
        ey2_next   = ey2_reg;
        q_next     = q_reg;
        acc_next   = acc_reg;
        cctl.op    = cbs_pkg::CELL_HOLD;
        cctl.phase = step_reg[0];
        wr_idx     = '0;
        tail_box   = head_box;
        tail_dead  = 1'b1;
        mv_next    = mv_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    q_next     = in_box;
                    hit_next   = 1'b0;
                    ovf_next   = 1'b0;
                    chg_next   = 1'b0;
                    keep_next  = '0;
                    step_next  = '0;
                    state_next = ST_FIN;
                    unique case (s_op)
                        OP_CLEAR: begin
                            count_next = '0;
                            clip_next  = 1'b0;
                            allc_next  = 1'b0;
                            ex1_next = '0; ey1_next = '0; ex2_next = '0; ey2_next = '0;
                        end
                        OP_APPEND: begin
                            if (allc_reg) begin
                                // clip is empty, box ignored
                            end else if (!clip_reg || count_reg == '0) begin
                                cctl.op    = cbs_pkg::CELL_LOAD;
                                clip_next  = 1'b1;
                                count_next = CNT_W'(1);
                                ex1_next = rx1; ey1_next = ry1; ex2_next = rx2; ey2_next = ry2;
                            end else if (count_reg == CNT_W'(MAX_BOXES)) begin
                                ovf_next = 1'b1;
                            end else begin
                                cctl.op    = cbs_pkg::CELL_LOAD;
                                wr_idx     = count_reg[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                                if (rx1 < ex1_reg) ex1_next = rx1;
                                if (ry1 < ey1_reg) ey1_next = ry1;
                                if (rx2 > ex2_reg) ex2_next = rx2;
                                if (ry2 > ey2_reg) ey2_next = ry2;
                            end
                        end
                        OP_INTERSECT: begin
                            priority if (allc_reg) begin
                            end else if (rx2 <= rx1 || ry2 <= ry1) begin
                                clip_next  = 1'b1;
                                allc_next  = 1'b1;
                                count_next = '0;
                                ex1_next = '0; ey1_next = '0; ex2_next = '0; ey2_next = '0;
                            end else if (!clip_reg || count_reg == '0) begin
                                cctl.op    = cbs_pkg::CELL_LOAD;
                                clip_next  = 1'b1;
                                count_next = CNT_W'(1);
                                ex1_next = rx1; ey1_next = ry1; ex2_next = rx2; ey2_next = ry2;
                            end else if (count_reg == CNT_W'(1) && holds(in_box, head_box)) begin
                                // single box already inside: unchanged
                            end else begin
                                mode_next  = MODE_CLAMP;
                                state_next = ST_ROT;
                            end
                        end
                        OP_CONTAINS: begin
                            priority if (!clip_reg) begin
                                hit_next = 1'b1;
                            end else if (allc_reg) begin
                            end else if (rx1 < ex1_reg || ry1 < ey1_reg ||
                                         rx2 > ex2_reg || ry2 > ey2_reg) begin
                            end else if (count_reg == '0) begin
                                hit_next = 1'b1;
                            end else begin
                                mode_next  = MODE_HIT;
                                state_next = ST_ROT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_ROT: begin
                // one full turn of the ring restores the original order
                cctl.op   = cbs_pkg::CELL_ROT;
                tail_dead = head_dead;
                step_next = step_reg + IDX_W'(1);
                unique case (mode_reg)
                    MODE_CLAMP: begin
                        tail_box  = clamped;
                        tail_dead = !(in_use && clamp_live);
                        if (in_use && clamp_chg)  chg_next  = 1'b1;
                        if (in_use && clamp_live) keep_next = keep_reg + CNT_W'(1);
                    end
                    MODE_EXT: begin
                        if (step_reg == '0) begin
                            acc_next = head_box;
                        end else if (in_use) begin
                            if (head_box.x1 < acc_reg.x1) acc_next.x1 = head_box.x1;
                            if (head_box.y1 < acc_reg.y1) acc_next.y1 = head_box.y1;
                            if (head_box.x2 > acc_reg.x2) acc_next.x2 = head_box.x2;
                            if (head_box.y2 > acc_reg.y2) acc_next.y2 = head_box.y2;
                        end
                    end
                    MODE_HIT: begin
                        if (in_use && holds(head_box, q_reg)) hit_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (last_step) begin
                    step_next = '0;
                    unique case (mode_reg)
                        MODE_CLAMP: begin
                            count_next = keep_next;
                            state_next = ST_SORT;
                        end
                        MODE_EXT: begin
                            ex1_next   = rfloor(acc_next.x1);
                            ey1_next   = rfloor(acc_next.y1);
                            ex2_next   = rceil(acc_next.x2);
                            ey2_next   = rceil(acc_next.y2);
                            state_next = ST_FIN;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_SORT: begin
                // odd-even transposition: MAX_BOXES phases move dead boxes up
                cctl.op   = cbs_pkg::CELL_SORT;
                step_next = step_reg + IDX_W'(1);
                if (last_step) begin
                    step_next = '0;
                    if (count_reg == '0) begin
                        clip_next  = 1'b1;
                        allc_next  = 1'b1;
                        ex1_next = '0; ey1_next = '0; ex2_next = '0; ey2_next = '0;
                        state_next = ST_FIN;
                    end else if (chg_reg) begin
                        mode_next  = MODE_EXT;
                        state_next = ST_ROT;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_FIN: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_CLAMP;
            step_reg  <= '0;
            count_reg <= '0;
            keep_reg  <= '0;
            clip_reg  <= 1'b0;
            allc_reg  <= 1'b0;
            chg_reg   <= 1'b0;
            hit_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            ex1_reg   <= '0;
            ey1_reg   <= '0;
            ex2_reg   <= '0;
            ey2_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            keep_reg  <= keep_next;
            clip_reg  <= clip_next;
            allc_reg  <= allc_next;
            chg_reg   <= chg_next;
            hit_reg   <= hit_next;
            ovf_reg   <= ovf_next;
            ex1_reg   <= ex1_next;
            ey1_reg   <= ey1_next;
            ex2_reg   <= ex2_next;
            ey2_reg   <= ey2_next;
            mv_reg    <= mv_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        acc_reg <= acc_next;
        if (state_reg == ST_FIN && (!mv_reg || m_ready)) begin
            o_cont_reg <= hit_reg;
            o_allc_reg <= allc_reg;
            o_uncl_reg <= !clip_reg;
            o_cnt_reg  <= 5'(count_reg);
            o_x_reg    <= sat_s24(ex1_reg);
            o_y_reg    <= sat_s24(ey1_reg);
            o_w_reg    <= sat_u24(ex2_reg, ex1_reg);
            o_h_reg    <= sat_u24(ey2_reg, ey1_reg);
            o_ovf_reg  <= ovf_reg;
        end
    end

    assign m_valid              = mv_reg;
    assign m_contained          = o_cont_reg;
    assign m_everything_clipped = o_allc_reg;
    assign m_unclipped          = o_uncl_reg;
    assign m_count_out          = o_cnt_reg;
    assign m_extent_x           = o_x_reg;
    assign m_extent_y           = o_y_reg;
    assign m_extent_width       = o_w_reg;
    assign m_extent_height      = o_h_reg;
    assign m_overflow           = o_ovf_reg;

endmodule

`default_nettype wire
